>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk_i and muted while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PLQM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("plqm assertion failed");

// condition must never be seen at a clock edge out of reset
`define PLQM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("plqm forbidden condition seen");

`endif

>>> src/plqm_pkg.sv
// ----------------------------------------------------------------------------
// plqm_pkg
// request and response types, command codes and memory control bundle
// ----------------------------------------------------------------------------
package plqm_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned QueueW = 3;
  localparam int unsigned EntryW = 5;

  localparam logic [CmdW-1:0] CmdAlloc   = 3'd0;
  localparam logic [CmdW-1:0] CmdFree    = 3'd1;
  localparam logic [CmdW-1:0] CmdMkEmpty = 3'd2;
  localparam logic [CmdW-1:0] CmdAppend  = 3'd3;
  localparam logic [CmdW-1:0] CmdPeek    = 3'd4;
  localparam logic [CmdW-1:0] CmdPop     = 3'd5;
  localparam logic [CmdW-1:0] CmdRemove  = 3'd6;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [QueueW-1:0] queue_id;
    logic [EntryW-1:0] entry_in;
  } cmd_req_t;

  typedef struct packed {
    logic              found;
    logic [EntryW-1:0] entry_out;
  } cmd_rsp_t;

  // write enables of the link and queue memories
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic qm_we;
  } mem_ctl_t;

endpackage

>>> src/plqm_ram.sv
// ----------------------------------------------------------------------------
// plqm_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module plqm_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 5,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/plqm_seq.sv
// ----------------------------------------------------------------------------
// plqm_seq
// command sequencer: free list registers, queue flags and memory accesses
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plqm_seq #(
  parameter int unsigned POOL_SIZE  = 32,
  parameter int unsigned NUM_QUEUES = 8,
  localparam int unsigned EW = $clog2(POOL_SIZE),
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  plqm_pkg::cmd_req_t req_i,
  output logic               busy_o,
  output logic               rsp_valid_o,
  output plqm_pkg::cmd_rsp_t rsp_o,
  output plqm_pkg::mem_ctl_t mem_ctl_o,
  output logic [EW-1:0]      next_raddr_o,
  input  logic [EW-1:0]      next_rdata_i,
  output logic [EW-1:0]      next_waddr_o,
  output logic [EW-1:0]      next_wdata_o,
  output logic [EW-1:0]      prev_raddr_o,
  input  logic [EW-1:0]      prev_rdata_i,
  output logic [EW-1:0]      prev_waddr_o,
  output logic [EW-1:0]      prev_wdata_o,
  output logic [QW-1:0]      qm_raddr_o,
  input  logic [2*EW-1:0]    qm_rdata_i,
  output logic [QW-1:0]      qm_waddr_o,
  output logic [2*EW-1:0]    qm_wdata_o
);

  localparam int unsigned CW = $clog2(POOL_SIZE + 1);
  localparam int unsigned WW = $clog2(POOL_SIZE);
  localparam int unsigned OW = plqm_pkg::EntryW;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ALLOC   = 6'b000010,
    S_QRD     = 6'b000100,
    S_WALK    = 6'b001000,
    S_WALK_NX = 6'b010000,
    S_UNL     = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  logic [EW-1:0]                free_head_q, free_head_d;
  logic [CW-1:0]                free_count_q, free_count_d;
  logic [NUM_QUEUES-1:0]        nonempty_q, nonempty_d;
  logic [plqm_pkg::CmdW-1:0]    cmd_q, cmd_d;
  logic [QW-1:0]                qid_q, qid_d;
  logic [EW-1:0]                ent_q, ent_d;
  logic [EW-1:0]                head_q, head_d;
  logic [EW-1:0]                tail_q, tail_d;
  logic [EW-1:0]                cur_q, cur_d;
  logic [EW-1:0]                tgt_q, tgt_d;
  logic [WW-1:0]                walk_n_q, walk_n_d;
  logic                         rsp_valid_q, rsp_valid_d;
  plqm_pkg::cmd_rsp_t           rsp_q, rsp_d;

  logic          in_e_ok, in_q_ok;
  logic [EW-1:0] in_ent;
  logic [QW-1:0] in_qid;
  logic [EW-1:0] qm_head, qm_tail;

  assign in_e_ok = 32'(req_i.entry_in) < 32'(POOL_SIZE);
  assign in_q_ok = 32'(req_i.queue_id) < 32'(NUM_QUEUES);
  assign in_ent  = EW'(req_i.entry_in);
  assign in_qid  = QW'(req_i.queue_id);
  assign qm_head = qm_rdata_i[2*EW-1:EW];
  assign qm_tail = qm_rdata_i[EW-1:0];

  always_comb begin
    state_d      = state_q;
    free_head_d  = free_head_q;
    free_count_d = free_count_q;
    nonempty_d   = nonempty_q;
    cmd_d        = cmd_q;
    qid_d        = qid_q;
    ent_d        = ent_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cur_d        = cur_q;
    tgt_d        = tgt_q;
    walk_n_d     = walk_n_q;
    rsp_valid_d  = 1'b0;
    rsp_d        = '0;
    mem_ctl_o    = '0;
    next_raddr_o = cur_q;
    next_waddr_o = '0;
    next_wdata_o = '0;
    prev_raddr_o = tgt_q;
    prev_waddr_o = '0;
    prev_wdata_o = '0;
    qm_raddr_o   = in_qid;
    qm_waddr_o   = '0;
    qm_wdata_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = req_i.command;
          qid_d = in_qid;
          ent_d = in_ent;
          rsp_valid_d = 1'b1;
          unique case (req_i.command)
            plqm_pkg::CmdAlloc: begin
              if (free_count_q != '0) begin
                next_raddr_o = free_head_q;
                rsp_valid_d  = 1'b0;
                state_d      = S_ALLOC;
              end
            end
            plqm_pkg::CmdFree: begin
              if (in_e_ok) begin
                mem_ctl_o.next_we = 1'b1;
                next_waddr_o      = in_ent;
                next_wdata_o      = free_head_q;
                free_head_d       = in_ent;
                if (free_count_q != CW'(POOL_SIZE)) begin
                  free_count_d = free_count_q + CW'(1);
                end
              end
            end
            plqm_pkg::CmdMkEmpty: begin
              if (in_q_ok) begin
                nonempty_d[in_qid] = 1'b0;
              end
            end
            plqm_pkg::CmdAppend: begin
              if (in_q_ok && in_e_ok) begin
                if (nonempty_q[in_qid]) begin
                  // need the old tail first
                  rsp_valid_d = 1'b0;
                  state_d     = S_QRD;
                end else begin
                  mem_ctl_o.qm_we    = 1'b1;
                  qm_waddr_o         = in_qid;
                  qm_wdata_o         = {in_ent, in_ent};
                  nonempty_d[in_qid] = 1'b1;
                end
              end
            end
            plqm_pkg::CmdPeek, plqm_pkg::CmdPop: begin
              if (in_q_ok && nonempty_q[in_qid]) begin
                rsp_valid_d = 1'b0;
                state_d     = S_QRD;
              end
            end
            plqm_pkg::CmdRemove: begin
              if (in_q_ok && in_e_ok && nonempty_q[in_qid]) begin
                rsp_valid_d = 1'b0;
                state_d     = S_QRD;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_ALLOC: begin
        free_head_d     = next_rdata_i;
        free_count_d    = free_count_q - CW'(1);
        rsp_valid_d     = 1'b1;
        rsp_d.found     = 1'b1;
        rsp_d.entry_out = OW'(free_head_q);
        state_d         = S_IDLE;
      end

      S_QRD: begin
        head_d = qm_head;
        tail_d = qm_tail;
        unique case (cmd_q)
          plqm_pkg::CmdAppend: begin
            mem_ctl_o.next_we = 1'b1;
            next_waddr_o      = qm_tail;
            next_wdata_o      = ent_q;
            mem_ctl_o.prev_we = 1'b1;
            prev_waddr_o      = ent_q;
            prev_wdata_o      = qm_tail;
            mem_ctl_o.qm_we   = 1'b1;
            qm_waddr_o        = qid_q;
            qm_wdata_o        = {qm_head, ent_q};
            rsp_valid_d       = 1'b1;
            state_d           = S_IDLE;
          end
          plqm_pkg::CmdPeek: begin
            rsp_valid_d     = 1'b1;
            rsp_d.found     = 1'b1;
            rsp_d.entry_out = OW'(qm_head);
            state_d         = S_IDLE;
          end
          plqm_pkg::CmdPop: begin
            // unlink the head: fetch both of its links
            tgt_d        = qm_head;
            next_raddr_o = qm_head;
            prev_raddr_o = qm_head;
            state_d      = S_UNL;
          end
          default: begin
            cur_d    = qm_head;
            walk_n_d = '0;
            state_d  = S_WALK;
          end
        endcase
      end

      S_WALK: begin
        priority if (cur_q == ent_q) begin
          tgt_d        = ent_q;
          next_raddr_o = ent_q;
          prev_raddr_o = ent_q;
          state_d      = S_UNL;
        end else if (cur_q == tail_q || walk_n_q == WW'(POOL_SIZE - 1)) begin
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          next_raddr_o = cur_q;
          state_d      = S_WALK_NX;
        end
      end

      S_WALK_NX: begin
        cur_d    = next_rdata_i;
        walk_n_d = walk_n_q + WW'(1);
        state_d  = S_WALK;
      end

      S_UNL: begin
        priority if (tgt_q == head_q && tgt_q == tail_q) begin
          nonempty_d[qid_q] = 1'b0;
        end else if (tgt_q == head_q) begin
          mem_ctl_o.qm_we = 1'b1;
          qm_waddr_o      = qid_q;
          qm_wdata_o      = {next_rdata_i, tail_q};
        end else if (tgt_q == tail_q) begin
          mem_ctl_o.qm_we = 1'b1;
          qm_waddr_o      = qid_q;
          qm_wdata_o      = {head_q, prev_rdata_i};
        end else begin
          mem_ctl_o.next_we = 1'b1;
          next_waddr_o      = prev_rdata_i;
          next_wdata_o      = next_rdata_i;
          mem_ctl_o.prev_we = 1'b1;
          prev_waddr_o      = next_rdata_i;
          prev_wdata_o      = prev_rdata_i;
        end
        rsp_valid_d     = 1'b1;
        rsp_d.found     = 1'b1;
        rsp_d.entry_out = OW'(tgt_q);
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_head_q  <= EW'(POOL_SIZE - 1);
      free_count_q <= CW'(POOL_SIZE);
      nonempty_q   <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      free_count_q <= free_count_d;
      nonempty_q   <= nonempty_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    qid_q    <= qid_d;
    ent_q    <= ent_d;
    head_q   <= head_d;
    tail_q   <= tail_d;
    cur_q    <= cur_d;
    tgt_q    <= tgt_d;
    walk_n_q <= walk_n_d;
    rsp_q    <= rsp_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `PLQM_ASSERT(rsp_has_origin,
    rsp_valid_o |-> ($past(start_i && state_q == S_IDLE) || $past(state_q != S_IDLE)))
  `PLQM_ASSERT_NEVER(free_count_overflow, free_count_q > CW'(POOL_SIZE))
  `PLQM_ASSERT(unlink_after_lookup,
    state_q == S_UNL |-> ($past(state_q == S_QRD) || $past(state_q == S_WALK)))

endmodule

>>> src/pooled_linked_queue_manager_core.sv
// ----------------------------------------------------------------------------
// pooled_linked_queue_manager_core
// pooled entries shared by a lifo free list and fifo queues, linked in memory
// ----------------------------------------------------------------------------
// free, make_empty, append to an empty queue and rejected requests answer
//   straight from idle; alloc, peek and append read a memory first, pop also
//   unlinks the head, and remove walks the queue entry by entry and unlinks on a hit
// throughput: one request at a time, busy is high until the last memory update
// reset: a sweep over every entry loads the link memories, busy stays high;
//   results are a one-cycle strobe that the receiver cannot stall
module pooled_linked_queue_manager_core #(
  parameter int unsigned POOL_SIZE  = 32,
  parameter int unsigned NUM_QUEUES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  plqm_pkg::cmd_req_t req_i,
  output logic               rsp_valid_o,
  output plqm_pkg::cmd_rsp_t rsp_o
);

  `include "assert_macros.svh"

  localparam int unsigned EW = $clog2(POOL_SIZE);
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // init sweep state
  logic          init_busy_q, init_busy_d;
  logic [EW-1:0] init_idx_q, init_idx_d;
  logic          init_last;

  // sequencer side of the memories
  plqm_pkg::mem_ctl_t seq_ctl;
  logic               seq_busy;
  logic [EW-1:0]      next_raddr, next_rdata, seq_next_waddr, seq_next_wdata;
  logic [EW-1:0]      prev_raddr, prev_rdata, seq_prev_waddr, seq_prev_wdata;
  logic [QW-1:0]      qm_raddr, qm_waddr;
  logic [2*EW-1:0]    qm_rdata, qm_wdata;

  // memory write ports after the init mux
  logic          next_we, prev_we;
  logic [EW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

  assign init_last = (init_idx_q == EW'(POOL_SIZE - 1));

  always_comb begin
    init_busy_d = init_busy_q;
    init_idx_d  = init_idx_q;
    if (init_busy_q) begin
      init_idx_d = init_idx_q + EW'(1);
      if (init_last) begin
        init_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      init_idx_q  <= '0;
    end else begin
      init_busy_q <= init_busy_d;
      init_idx_q  <= init_idx_d;
    end
  end

  // during the sweep entry i gets next = i - 1 and prev = i + 1, both wrapping
  always_comb begin
    if (init_busy_q) begin
      next_we    = 1'b1;
      next_waddr = init_idx_q;
      next_wdata = (init_idx_q == '0) ? EW'(POOL_SIZE - 1) : init_idx_q - EW'(1);
      prev_we    = 1'b1;
      prev_waddr = init_idx_q;
      prev_wdata = init_last ? '0 : init_idx_q + EW'(1);
    end else begin
      next_we    = seq_ctl.next_we;
      next_waddr = seq_next_waddr;
      next_wdata = seq_next_wdata;
      prev_we    = seq_ctl.prev_we;
      prev_waddr = seq_prev_waddr;
      prev_wdata = seq_prev_wdata;
    end
  end

  // requests are held off until the sweep is done
  assign busy = init_busy_q | seq_busy;

  plqm_seq #(
    .POOL_SIZE  (POOL_SIZE),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start & ~init_busy_q),
    .req_i        (req_i),
    .busy_o       (seq_busy),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_o        (rsp_o),
    .mem_ctl_o    (seq_ctl),
    .next_raddr_o (next_raddr),
    .next_rdata_i (next_rdata),
    .next_waddr_o (seq_next_waddr),
    .next_wdata_o (seq_next_wdata),
    .prev_raddr_o (prev_raddr),
    .prev_rdata_i (prev_rdata),
    .prev_waddr_o (seq_prev_waddr),
    .prev_wdata_o (seq_prev_wdata),
    .qm_raddr_o   (qm_raddr),
    .qm_rdata_i   (qm_rdata),
    .qm_waddr_o   (qm_waddr),
    .qm_wdata_o   (qm_wdata)
  );

  // forward links: free list and queues
  plqm_ram #(
    .DEPTH (POOL_SIZE),
    .WIDTH (EW)
  ) u_next_mem (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  // backward links: queues only
  plqm_ram #(
    .DEPTH (POOL_SIZE),
    .WIDTH (EW)
  ) u_prev_mem (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  // per-queue head and tail, only used while the queue is marked nonempty
  plqm_ram #(
    .DEPTH (NUM_QUEUES),
    .WIDTH (2 * EW)
  ) u_queue_mem (
    .clk_i   (clk_i),
    .we_i    (seq_ctl.qm_we),
    .waddr_i (qm_waddr),
    .wdata_i (qm_wdata),
    .raddr_i (qm_raddr),
    .rdata_o (qm_rdata)
  );

  `PLQM_ASSERT(init_ends_on_last_entry,
    $fell(init_busy_q) |-> $past(init_idx_q) == EW'(POOL_SIZE - 1))

endmodule
